FILE: rtl/bmg_pkg.sv
// Shared constants, types and the arctangent table of the Box-Muller unit.
// No dependencies.
package bmg_pkg;
	localparam int UNI_W      = 32;
	localparam int OUT_W      = 16;
	localparam int OUT_FRAC   = 12;
	localparam int RAD_FRAC   = 24;
	localparam int RND_SH     = RAD_FRAC - OUT_FRAC;
	localparam int LOG_STEPS  = 32;
	localparam int K_W        = 5;
	localparam int BIGL_W     = 38;
	localparam int W_W        = 38;
	localparam int SQ_IN_W    = 56;
	localparam int SQ_STEPS   = SQ_IN_W / 2;
	localparam int ROOT_W     = SQ_STEPS;
	localparam int REM_W      = ROOT_W + 4;
	localparam int CORDIC_N   = 28;
	localparam int XY_W       = 32;
	localparam int Z_W        = 34;
	localparam int SIDE_W     = UNI_W;

	localparam logic [31:0] TWO_LN2_Q31     = 32'd2977044472;
	localparam logic [30:0] CORDIC_GAIN_Q31 = 31'd1304065748;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef logic [31:0] atan_tab_t [0:CORDIC_N-1];
	localparam atan_tab_t ATAN_TURNS = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	typedef struct packed {
		logic signed [OUT_W-1:0] gauss_cos;
		logic signed [OUT_W-1:0] gauss_sin;
	} gauss_pair_t;
endpackage

FILE: rtl/bmg_if.sv
// Valid/ready channel interfaces for uniform input items and Gaussian result items.
// Depends on bmg_pkg.
interface bmg_uni_if import bmg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [UNI_W-1:0] u_radius;
	logic [UNI_W-1:0] u_angle;
	modport source (output valid, u_radius, u_angle, input ready);
	modport sink (input valid, u_radius, u_angle, output ready);
endinterface

interface bmg_gauss_if import bmg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] gauss_cos;
	logic signed [OUT_W-1:0] gauss_sin;
	modport source (output valid, gauss_cos, gauss_sin, input ready);
	modport sink (input valid, gauss_cos, gauss_sin, output ready);
endinterface

FILE: rtl/box_muller_gaussian_pair_unit.sv
// Box-Muller Gaussian pair generator, top level.
// Depends on bmg_pkg, bmg_if, bmg_log, bmg_sqrt, bmg_cordic.
//
// Usage:
//   uni   : sink channel of uniform pairs (u_radius, u_angle), codes / 2^32.
//           A u_radius code of zero counts as one.
//   gauss : source channel of normal pairs (gauss_cos, gauss_sin), signed Q4.12.
//   One result item for every input item, in order.
// Pipeline: 34 log stages, 28 root stages, 1 gain stage, 1 fold stage, 28 rotation
//   stages and rounding into the output buffer; a receiver stall holds the pipeline.
// Throughput: one item per cycle while the output buffer is not full. The whole
//   pipeline moves on one enable; a two-entry output buffer takes the pipeline's
//   output, and uni.ready drops only while that buffer is full, so a stall loses
//   and repeats nothing.
// Reset: arst_n clears all valid bits and the buffer count and pointers, not data.
module box_muller_gaussian_pair_unit import bmg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bmg_uni_if.sink      uni,
	bmg_gauss_if.source  gauss
);
	logic                   en;
	logic                   lg_valid;
	logic [W_W-1:0]         lg_w;
	logic [SIDE_W-1:0]      lg_side;
	logic                   sq_valid;
	logic [ROOT_W-1:0]      sq_root;
	logic [SIDE_W-1:0]      sq_side;
	logic                   cd_valid;
	logic signed [XY_W-1:0] cd_x;
	logic signed [XY_W-1:0] cd_y;
	gauss_pair_t            res;
	gauss_pair_t            buf_q [0:1];
	logic                   wp_q;
	logic                   rp_q;
	logic [1:0]             cnt_q;
	logic                   push;
	logic                   pop;

	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
		logic signed [XY_W:0] r;
		r = (XY_W+1)'(v) + (XY_W+1)'(signed'(1 << (RND_SH - 1)));
		r = r >>> RND_SH;
		if (r > (XY_W+1)'(32767)) begin
			return 16'sh7FFF;
		end else if (r < -(XY_W+1)'(32768)) begin
			return 16'sh8000;
		end
		return r[OUT_W-1:0];
	endfunction

	assign en        = (cnt_q != 2'd2);
	assign uni.ready = en;

	bmg_log u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (uni.valid),
		.u_radius (uni.u_radius),
		.side_in  (uni.u_angle),
		.out_valid(lg_valid),
		.w        (lg_w),
		.side_out (lg_side)
	);

	bmg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (lg_valid),
		.w        (lg_w),
		.side_in  (lg_side),
		.out_valid(sq_valid),
		.root     (sq_root),
		.side_out (sq_side)
	);

	bmg_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.root     (sq_root),
		.phase    (sq_side),
		.out_valid(cd_valid),
		.x_out    (cd_x),
		.y_out    (cd_y)
	);

	assign res.gauss_cos = round_sat(cd_x);
	assign res.gauss_sin = round_sat(cd_y);
	assign push = en && cd_valid;
	assign pop  = gauss.valid && gauss.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= res;
	end

	assign gauss.valid     = (cnt_q != 2'd0);
	assign gauss.gauss_cos = buf_q[rp_q].gauss_cos;
	assign gauss.gauss_sin = buf_q[rp_q].gauss_sin;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output buffer count out of range");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !gauss.ready) |=> (cnt_q == 2'd2))
		else $error("full buffer changed without a pop");
	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wp_q == rp_q))
		else $error("buffer pointers disagree with count");
`endif
endmodule

FILE: rtl/bmg_log.sv
// Pipelined -2 ln(u) unit: normalize, 32 squaring log2 stages, scale by 2 ln 2.
// Depends on bmg_pkg.
module bmg_log import bmg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [UNI_W-1:0]  u_radius,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [W_W-1:0]    w,
	output logic [SIDE_W-1:0] side_out
);
	logic [UNI_W-1:0]  code;
	logic [K_W-1:0]    k;
	logic              v_s   [0:LOG_STEPS+1];
	logic [31:0]       m_s   [0:LOG_STEPS];
	logic [31:0]       lf_s  [0:LOG_STEPS];
	logic [K_W-1:0]    k_s   [0:LOG_STEPS];
	logic [SIDE_W-1:0] sd_s  [0:LOG_STEPS+1];
	logic [W_W-1:0]    w_s;
	logic [BIGL_W-1:0] big_l;
	logic [63:0]       lo_prod;
	logic [37:0]       hi_prod;

	always_comb begin
		code = (u_radius == '0) ? UNI_W'(1) : u_radius;
		k = '0;
		for (int i = 0; i < UNI_W; i++) begin
			if (code[i]) k = K_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= code << (K_W'(31) - k);
			lf_s[0] <= '0;
			k_s[0]  <= k;
			sd_s[0] <= side_in;
		end
	end

	for (genvar g = 0; g < LOG_STEPS; g++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = m_s[g] * m_s[g];
		assign t  = sq[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[g+1]  <= t[32] ? t[32:1] : t[31:0];
				lf_s[g+1] <= {lf_s[g][30:0], t[32]};
				k_s[g+1]  <= k_s[g];
				sd_s[g+1] <= sd_s[g];
			end
		end
	end

	assign big_l   = {6'(6'd32 - {1'b0, k_s[LOG_STEPS]}), 32'd0} - {6'd0, lf_s[LOG_STEPS]};
	assign lo_prod = big_l[31:0] * TWO_LN2_Q31;
	assign hi_prod = big_l[37:32] * TWO_LN2_Q31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[LOG_STEPS+1] <= 1'b0;
		end else if (en) begin
			v_s[LOG_STEPS+1] <= v_s[LOG_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s              <= hi_prod + {6'd0, lo_prod[63:32]};
			sd_s[LOG_STEPS+1] <= sd_s[LOG_STEPS];
		end
	end

	assign out_valid = v_s[LOG_STEPS+1];
	assign w         = w_s;
	assign side_out  = sd_s[LOG_STEPS+1];
endmodule

FILE: rtl/bmg_sqrt.sv
// Pipelined floor square root of w * 2^17, one result bit per stage.
// Depends on bmg_pkg.
module bmg_sqrt import bmg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [W_W-1:0]    w,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);
	logic              v_s   [0:SQ_STEPS];
	logic [SQ_IN_W-1:0] rad_s [0:SQ_STEPS];
	logic [ROOT_W-1:0] rt_s  [0:SQ_STEPS];
	logic [REM_W-1:0]  rm_s  [0:SQ_STEPS];
	logic [SIDE_W-1:0] sd_s  [0:SQ_STEPS];

	assign v_s[0]   = in_valid;
	assign rad_s[0] = SQ_IN_W'({w, 17'd0});
	assign rt_s[0]  = '0;
	assign rm_s[0]  = '0;
	assign sd_s[0]  = side_in;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_bit
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             take;
		assign rem_sh = {rm_s[g][REM_W-3:0], rad_s[g][SQ_IN_W-1:SQ_IN_W-2]};
		assign trial  = {2'b00, rt_s[g], 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1] <= {rad_s[g][SQ_IN_W-3:0], 2'b00};
				rm_s[g+1]  <= take ? rem_sh - trial : rem_sh;
				rt_s[g+1]  <= {rt_s[g][ROOT_W-2:0], take};
				sd_s[g+1]  <= sd_s[g];
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS];
	assign root      = rt_s[SQ_STEPS];
	assign side_out  = sd_s[SQ_STEPS];
endmodule

FILE: rtl/bmg_cordic.sv
// Gain scaling, quadrant fold and 28 pipelined CORDIC rotation stages.
// Depends on bmg_pkg.
module bmg_cordic import bmg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [ROOT_W-1:0]      root,
	input  logic [SIDE_W-1:0]      phase,
	output logic                   out_valid,
	output logic signed [XY_W-1:0] x_out,
	output logic signed [XY_W-1:0] y_out
);
	logic                   v_m_s1;
	logic [ROOT_W-1:0]      x0_s1;
	logic [31:0]            ph_s1;
	logic [ROOT_W+30:0]     gprod;
	logic                   v_s [0:CORDIC_N];
	logic signed [XY_W-1:0] x_s [0:CORDIC_N];
	logic signed [XY_W-1:0] y_s [0:CORDIC_N];
	logic signed [Z_W-1:0]  z_s [0:CORDIC_N];
	logic [31:0]            ph_rnd;
	logic [1:0]             quad;
	logic [31:0]            resid;
	logic signed [XY_W-1:0] x0_ext;

	assign gprod = root * CORDIC_GAIN_Q31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m_s1 <= 1'b0;
		end else if (en) begin
			v_m_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s1 <= gprod[ROOT_W+30:31];
			ph_s1 <= phase;
		end
	end

	assign ph_rnd = ph_s1 + 32'h2000_0000;
	assign quad   = ph_rnd[31:30];
	assign resid  = ph_s1 - {quad, 30'd0};
	assign x0_ext = XY_W'(signed'({1'b0, x0_s1}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_m_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= Z_W'(signed'(resid));
			unique case (quad)
				QUAD_0: begin
					x_s[0] <= x0_ext;
					y_s[0] <= '0;
				end
				QUAD_1: begin
					x_s[0] <= '0;
					y_s[0] <= x0_ext;
				end
				QUAD_2: begin
					x_s[0] <= -x0_ext;
					y_s[0] <= '0;
				end
				QUAD_3: begin
					x_s[0] <= '0;
					y_s[0] <= -x0_ext;
				end
				default: begin
					x_s[0] <= '0;
					y_s[0] <= '0;
				end
			endcase
		end
	end

	for (genvar g = 0; g < CORDIC_N; g++) begin : g_rot
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		logic signed [Z_W-1:0]  da;
		assign dx = y_s[g] >>> g;
		assign dy = x_s[g] >>> g;
		assign da = Z_W'(signed'({1'b0, ATAN_TURNS[g]}));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[g][Z_W-1]) begin
					x_s[g+1] <= x_s[g] - dx;
					y_s[g+1] <= y_s[g] + dy;
					z_s[g+1] <= z_s[g] - da;
				end else begin
					x_s[g+1] <= x_s[g] + dx;
					y_s[g+1] <= y_s[g] - dy;
					z_s[g+1] <= z_s[g] + da;
				end
			end
		end
	end

	assign out_valid = v_s[CORDIC_N];
	assign x_out     = x_s[CORDIC_N];
	assign y_out     = y_s[CORDIC_N];
endmodule

FILE: tb/sv/tb_gauss_scoreboard.sv
// Scoreboard class for the Box-Muller unit: bit-exact fixed-point prediction and result checks.
// Depends on bmg_pkg.
package tb_gauss_sb_pkg;
	import bmg_pkg::*;

	class gauss_scoreboard;
		gauss_pair_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		static function longint unsigned root_floor(longint unsigned v);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		static function longint unsigned radius_of(logic [31:0] code_in);
			longint unsigned code, m, lf, big_l, w;
			int k;
			code = code_in;
			if (code == 0)
				code = 1;
			k = 31;
			while (code[k] == 1'b0)
				k--;
			m = code << (31 - k);
			lf = 0;
			for (int i = 0; i < 32; i++) begin
				m = (m * m) >> 31;
				lf <<= 1;
				if (m >= (64'd1 << 32)) begin
					lf |= 1;
					m >>= 1;
				end
			end
			big_l = (longint'(32 - k) << 32) - lf;
			w = (big_l >> 32) * 64'(TWO_LN2_Q31)
				+ (((big_l & 64'hFFFFFFFF) * 64'(TWO_LN2_Q31)) >> 32);
			return root_floor(w << 17);
		endfunction

		static function logic signed [15:0] round_out(longint v);
			longint r;
			r = (v + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return r[15:0];
		endfunction

		static function gauss_pair_t predict(logic [31:0] u_rad, logic [31:0] u_ang);
			longint unsigned rad;
			longint x0, x, y, z, dx, dy;
			logic [1:0] q;
			logic [31:0] resid;
			gauss_pair_t r;
			rad = radius_of(u_rad);
			x0 = longint'((rad * 64'(CORDIC_GAIN_Q31)) >> 31);
			q = 2'((({32'd0, u_ang}) + 64'h20000000) >> 30);
			resid = u_ang - {q, 30'd0};
			z = longint'(signed'(resid));
			case (q)
				QUAD_0: begin x = x0; y = 0; end
				QUAD_1: begin x = 0; y = x0; end
				QUAD_2: begin x = -x0; y = 0; end
				default: begin x = 0; y = -x0; end
			endcase
			for (int i = 0; i < CORDIC_N; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
				end else begin
					x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
				end
			end
			r.gauss_cos = round_out(x);
			r.gauss_sin = round_out(y);
			return r;
		endfunction

		function void note_uniform(logic [31:0] u_rad, logic [31:0] u_ang);
			pending.insert(pending.size(), predict(u_rad, u_ang));
		endfunction

		function void check_pair(logic signed [15:0] c, logic signed [15:0] s);
			gauss_pair_t e;
			if (pending.size() == 0) begin
				$error("unexpected result item cos=%0d sin=%0d", c, s);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (c !== e.gauss_cos) begin
				$error("gauss_cos: expected %0d, actual %0d", e.gauss_cos, c);
				errors++;
			end
			if (s !== e.gauss_sin) begin
				$error("gauss_sin: expected %0d, actual %0d", e.gauss_sin, s);
				errors++;
			end
		endfunction
	endclass
endpackage

FILE: tb/sv/tb_top.sv
// Top-level testbench of box_muller_gaussian_pair_unit: directed and random uniform items,
// random idling and back-pressure. Depends on bmg_pkg, bmg_if, tb_gauss_sb_pkg and the RTL.
module tb_top;
	import bmg_pkg::*;
	import tb_gauss_sb_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	bmg_uni_if uni ();
	bmg_gauss_if gauss ();
	gauss_scoreboard sb;
	bit quiet_tail;
	bit hold_gauss;
	int cycles;

	box_muller_gaussian_pair_unit uut (.clk(clk), .arst_n(arst_n), .uni(uni), .gauss(gauss));

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 0;
		uni.valid = 0;
		uni.u_radius = '0;
		uni.u_angle = '0;
		gauss.ready = 0;
		quiet_tail = 0;
		hold_gauss = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end
	initial cycles = 0;

	// accept and check results
	always @(posedge clk) begin
		if (arst_n && gauss.valid && gauss.ready)
			sb.check_pair(gauss.gauss_cos, gauss.gauss_sin);
	end

	// receiver stall pattern; hold_gauss requests a long hold of ready low
	initial begin
		int gap;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_gauss) begin
				gauss.ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_gauss = 0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 3);
				gauss.ready <= 0;
				repeat (gap - 1) @(posedge clk);
				@(posedge clk);
				gauss.ready <= 1;
			end else begin
				gauss.ready <= 1;
			end
			@(posedge clk);
		end
	end

	task automatic send_uniform(logic [31:0] ur, logic [31:0] ua);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			uni.valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		uni.valid <= 1;
		uni.u_radius <= ur;
		uni.u_angle <= ua;
		@(posedge clk);
		while (!uni.ready)
			@(posedge clk);
		sb.note_uniform(ur, ua);
	endtask

	task automatic drain();
		int guard;
		uni.valid <= 0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	logic [31:0] edge_rad [10] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000};
	logic [31:0] edge_ang [12] = '{32'd0, 32'h1FFF_FFFF, 32'h2000_0000, 32'h4000_0000,
		32'h5FFF_FFFF, 32'h6000_0000, 32'h8000_0000, 32'hA000_0000, 32'hC000_0000,
		32'hE000_0000, 32'hFFFF_FFFF, 32'h5555_5555};

	initial begin
		logic [31:0] ur;
		@(posedge clk iff arst_n);
		@(posedge clk);
		// directed
		for (int i = 0; i < 10; i++)
			send_uniform(edge_rad[i], edge_ang[i]);
		for (int i = 0; i < 12; i++)
			send_uniform(32'hFFFF_FFFF - i, edge_ang[i]);
		drain();
		// random, with a long receiver hold-off in the middle
		for (int n = 0; n < 700; n++) begin
			if (n == 200)
				hold_gauss = 1;
			if (n == 400)
				drain();
			if (n == 600)
				quiet_tail = 1;
			case ($urandom_range(0, 3))
				0: ur = $urandom_range(0, 15);
				1: ur = 32'hFFFF_FFFF - $urandom_range(0, 255);
				2: ur = 32'd1 << $urandom_range(0, 31);
				default: ur = $urandom;
			endcase
			send_uniform(ur, $urandom);
		end
		drain();
		uni.valid <= 0;
		repeat (120) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
